// ----- hdl/kcft_pkg.sv -----
package kcft_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  typedef enum logic [1:0] {
    StatusChanged    = 2'd0,
    StatusSuppressed = 2'd1,
    StatusFull       = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StUpdate
  } state_e;

  typedef struct packed {
    logic [31:0] registry;
    logic [7:0]  tag;
    logic [15:0] slot;
    logic [31:0] health;
    logic [31:0] shield;
    logic [31:0] revision;
  } row_t;

  function automatic logic is_nan(input logic [31:0] x);
    return x[30:0] > 31'h7F80_0000;
  endfunction

  // ieee equality on raw single bits
  function automatic logic float_eq(input logic [31:0] a, input logic [31:0] b);
    logic res;
    if (is_nan(a) || is_nan(b)) begin
      res = 1'b0;
    end else if (a[30:0] == 31'd0 && b[30:0] == 31'd0) begin
      res = 1'b1;
    end else begin
      res = (a == b);
    end
    return res;
  endfunction

endpackage

// ----- hdl/kcft_row_ram.sv -----
module kcft_row_ram (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [kcft_pkg::IdxW-1:0] rd_addr_i,
  output kcft_pkg::row_t            rd_data_o,
  input  logic                      wr_en_i,
  input  logic [kcft_pkg::IdxW-1:0] wr_addr_i,
  input  kcft_pkg::row_t            wr_data_i
);
  import kcft_pkg::*;

  row_t mem [TableDepth];
  row_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hdl/keyed_change_filter_table.sv -----
// Keyed change filter table. Each input transfer names one entity slot by registry key, slot
// type and slot index and carries two float levels; exactly one result transfer follows, with
// status 0 (change event, row levels and wrapped revision given), 1 (unchanged, suppressed) or
// 2 (table full), all other fields zero unless status is 0. Rows live in a single-port-read,
// single-port-write synchronous memory and are claimed in order from row 0 and never freed, so
// a fill count marks the used rows and no clearing pass is needed after reset. The lookup reads
// one row per cycle through that memory: an item is accepted in idle, then compared against the
// stored rows in the scan state, up to and including a match (against all filled rows when there
// is none, 64 at most, and none when the table is empty), then written back in the update state;
// an item is taken only when the previous one has finished, and a finished result waits in the
// output register while the next item is looked up, stalling the update state only if that result
// is still not taken.
module keyed_change_filter_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] registry_key_i,
  input  logic [7:0]  slot_type_i,
  input  logic [15:0] slot_index_i,
  input  logic [31:0] health_bits_i,
  input  logic [31:0] shield_bits_i,
  input  logic [63:0] event_tick_i,
  input  logic [63:0] event_sequence_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] out_registry_key_o,
  output logic [7:0]  out_slot_type_o,
  output logic [15:0] out_slot_index_o,
  output logic [31:0] out_health_bits_o,
  output logic [31:0] out_shield_bits_o,
  output logic [31:0] out_revision_o,
  output logic [63:0] out_tick_o,
  output logic [63:0] out_sequence_o
);
  import kcft_pkg::*;

  state_e state_q, state_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic hit_q, hit_d;

  logic [31:0] key_q;
  logic [7:0]  tag_q;
  logic [15:0] slot_q;
  logic [31:0] health_q;
  logic [31:0] shield_q;
  logic [63:0] tick_q;
  logic [63:0] seq_q;

  logic        out_valid_q;
  logic [1:0]  status_q;
  logic [31:0] out_key_q;
  logic [7:0]  out_tag_q;
  logic [15:0] out_slot_q;
  logic [31:0] out_health_q;
  logic [31:0] out_shield_q;
  logic [31:0] out_rev_q;
  logic [63:0] out_tick_q;
  logic [63:0] out_seq_q;

  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  row_t            rd_data;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  row_t            wr_data;

  logic    accept;
  logic    match;
  logic    last;
  logic    same;
  logic    full;
  logic    go;
  logic    load_out;
  status_e status;
  logic [31:0] new_rev;

  kcft_row_ram u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign accept = in_valid_i && (state_q == StIdle);
  assign match  = (rd_data.registry == key_q) && (rd_data.tag == tag_q)
               && (rd_data.slot == slot_q);
  assign last   = ({1'b0, idx_q} + (IdxW + 1)'(1)) == (IdxW + 1)'(fill_q);
  assign same   = float_eq(rd_data.health, health_q) && float_eq(rd_data.shield, shield_q);
  assign full   = !hit_q && (fill_q == CntW'(TableDepth));
  assign go     = !out_valid_q || out_ready_i;

  always_comb begin
    priority if (hit_q && same) begin
      status = StatusSuppressed;
    end else if (full) begin
      status = StatusFull;
    end else begin
      status = StatusChanged;
    end
  end

  assign new_rev = hit_q ? rd_data.revision + 32'd1 : 32'd1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = (fill_q == '0) ? StUpdate : StScan;
        end
      end
      StScan: begin
        if (match || last) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        if (go) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // datapath control
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = hit_q ? idx_q : fill_q[IdxW-1:0];
    load_out = 1'b0;
    idx_d    = idx_q;
    hit_d    = hit_q;
    fill_d   = fill_q;
    wr_data.registry = key_q;
    wr_data.tag      = tag_q;
    wr_data.slot     = slot_q;
    wr_data.health   = health_q;
    wr_data.shield   = shield_q;
    wr_data.revision = new_rev;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          rd_en = 1'b1;
          idx_d = '0;
          hit_d = 1'b0;
        end
      end
      StScan: begin
        if (match) begin
          hit_d = 1'b1;
        end else if (!last) begin
          rd_en   = 1'b1;
          rd_addr = idx_q + IdxW'(1);
          idx_d   = idx_q + IdxW'(1);
        end
      end
      StUpdate: begin
        if (go) begin
          load_out = 1'b1;
          if (status == StatusChanged) begin
            wr_en = 1'b1;
            if (!hit_q) begin
              fill_d = fill_q + CntW'(1);
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= '0;
      idx_q   <= '0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q    <= registry_key_i;
      tag_q    <= slot_type_i;
      slot_q   <= slot_index_i;
      health_q <= health_bits_i;
      shield_q <= shield_bits_i;
      tick_q   <= event_tick_i;
      seq_q    <= event_sequence_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_q <= status;
      if (status == StatusChanged) begin
        out_key_q    <= key_q;
        out_tag_q    <= tag_q;
        out_slot_q   <= slot_q;
        out_health_q <= health_q;
        out_shield_q <= shield_q;
        out_rev_q    <= new_rev;
        out_tick_q   <= tick_q;
        out_seq_q    <= seq_q;
      end else begin
        out_key_q    <= '0;
        out_tag_q    <= '0;
        out_slot_q   <= '0;
        out_health_q <= '0;
        out_shield_q <= '0;
        out_rev_q    <= '0;
        out_tick_q   <= '0;
        out_seq_q    <= '0;
      end
    end
  end

  assign in_ready_o         = (state_q == StIdle);
  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign out_registry_key_o = out_key_q;
  assign out_slot_type_o    = out_tag_q;
  assign out_slot_index_o   = out_slot_q;
  assign out_health_bits_o  = out_health_q;
  assign out_shield_bits_o  = out_shield_q;
  assign out_revision_o     = out_rev_q;
  assign out_tick_o         = out_tick_q;
  assign out_sequence_o     = out_seq_q;

endmodule
